### rtl/sdfw_pkg.sv
// shared types, constants and codes for the serial dac frame writer
package sdfw_pkg;

   localparam int CODE_BITS   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int MV_BITS     = 21;
   localparam int REF_BITS    = 16;
   localparam int HOLD_BITS   = 16;
   localparam int DEN_BITS    = REF_BITS + 1;
   localparam int QUO_BITS    = CODE_BITS + 1;
   localparam int NUM_BITS    = DEN_BITS + QUO_BITS;

   localparam logic [CODE_BITS-1:0] CODE_ZERO = '0;
   localparam logic [CODE_BITS-1:0] CODE_MAX  = '1;
   localparam logic [CODE_BITS-1:0] CODE_MID  = {1'b1, {(CODE_BITS-1){1'b0}}};

   localparam logic [REF_BITS-1:0]  REFERENCE_RESET  = 16'd2500;
   localparam logic                 LATCH_MODE_RESET = 1'b0;
   localparam logic [HOLD_BITS-1:0] PHASE_HOLD_RESET = 16'd4;
   localparam logic [HOLD_BITS-1:0] LATCH_HOLD_RESET = 16'd16;

   localparam logic [1:0] REQ_RAW      = 2'd0;
   localparam logic [1:0] REQ_UNIPOLAR = 2'd1;
   localparam logic [1:0] REQ_BIPOLAR  = 2'd2;

   typedef enum logic [1:0] {
      CSR_REFERENCE  = 2'd0,
      CSR_LATCH_MODE = 2'd1,
      CSR_PHASE_HOLD = 2'd2,
      CSR_LATCH_HOLD = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_SELECT,
      BACK_BITS,
      BACK_DESELECT,
      BACK_DATA_LOW,
      BACK_LATCH_LOW,
      BACK_LATCH_HIGH
   } back_state_type;

   typedef struct packed {
      logic                 valid;
      logic [CODE_BITS-1:0] code;
   } code_push_type;

   typedef struct packed {
      logic                 pulse_mode;
      logic [HOLD_BITS-1:0] phase_hold;
      logic [HOLD_BITS-1:0] latch_hold;
   } back_cfg_type;

endpackage

### rtl/spi_dac_frame_writer_top.sv
// top level of the serial dac frame writer: config registers, intake, queue, sequencer
// pin events: one per cycle while a frame is in progress and rsp_ready does not stall the output;
//   between writes the frame sequencer takes the next code from the queue in its idle state
// conversion uses a bit-serial divider that overlaps the previous frame
// reset: registers return to defaults, queue and sequencer empty, no clearing pass
module spi_dac_frame_writer_top #(
   parameter int QUEUE_DEPTH = sdfw_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [sdfw_pkg::REF_BITS-1:0]  csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [sdfw_pkg::CODE_BITS-1:0] req_raw_code,
   input  logic signed [sdfw_pkg::MV_BITS-1:0] req_target_millivolts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_chip_select_n,
   output logic                           rsp_serial_clock,
   output logic                           rsp_serial_data,
   output logic                           rsp_latch_n,
   output logic [sdfw_pkg::HOLD_BITS-1:0] rsp_hold_cycles,
   output logic [sdfw_pkg::CODE_BITS-1:0] rsp_sent_code,
   output logic                           rsp_last_event
);
   import sdfw_pkg::*;

   logic [REF_BITS-1:0]  reference_ff, reference_in;
   logic                 pulse_mode_ff, pulse_mode_in;
   logic [HOLD_BITS-1:0] phase_hold_ff, phase_hold_in;
   logic [HOLD_BITS-1:0] latch_hold_ff, latch_hold_in;

   code_push_type        push;
   back_cfg_type         back_cfg;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;
   logic [CODE_BITS-1:0] head_code;
   logic                 div_start;
   logic [NUM_BITS-1:0]  div_num;
   logic [DEN_BITS-1:0]  div_den;
   logic                 div_done;
   logic [QUO_BITS-1:0]  div_quotient;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      reference_in  = reference_ff;
      pulse_mode_in = pulse_mode_ff;
      phase_hold_in = phase_hold_ff;
      latch_hold_in = latch_hold_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REFERENCE:  reference_in  = csr_data;
            CSR_LATCH_MODE: pulse_mode_in = csr_data[0];
            CSR_PHASE_HOLD: phase_hold_in = csr_data;
            CSR_LATCH_HOLD: latch_hold_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff  <= REFERENCE_RESET;
         pulse_mode_ff <= LATCH_MODE_RESET;
         phase_hold_ff <= PHASE_HOLD_RESET;
         latch_hold_ff <= LATCH_HOLD_RESET;
      end else begin
         reference_ff  <= reference_in;
         pulse_mode_ff <= pulse_mode_in;
         phase_hold_ff <= phase_hold_in;
         latch_hold_ff <= latch_hold_in;
      end
   end

   assign back_cfg.pulse_mode = pulse_mode_ff;
   assign back_cfg.phase_hold = phase_hold_ff;
   assign back_cfg.latch_hold = latch_hold_ff;

   sdfw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   sdfw_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_raw_code          (req_raw_code),
      .req_target_millivolts (req_target_millivolts),
      .reference_mv          (reference_ff),
      .queue_full            (queue_full),
      .push                  (push),
      .div_start             (div_start),
      .div_num               (div_num),
      .div_den               (div_den),
      .div_done              (div_done),
      .div_quotient          (div_quotient)
   );

   sdfw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_code  (head_code)
   );

   sdfw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (back_cfg),
      .head_valid        (head_valid),
      .head_code         (head_code),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chip_select_n (rsp_chip_select_n),
      .rsp_serial_clock  (rsp_serial_clock),
      .rsp_serial_data   (rsp_serial_data),
      .rsp_latch_n       (rsp_latch_n),
      .rsp_hold_cycles   (rsp_hold_cycles),
      .rsp_sent_code     (rsp_sent_code),
      .rsp_last_event    (rsp_last_event)
   );

endmodule

### rtl/sdfw_divider.sv
// restoring divider, one quotient bit per cycle, for millivolt to code conversion
module sdfw_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sdfw_pkg::NUM_BITS-1:0] num,
   input  logic [sdfw_pkg::DEN_BITS-1:0] den,
   output logic                          done,
   output logic [sdfw_pkg::QUO_BITS-1:0] quotient
);
   import sdfw_pkg::*;

   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] lo_ff, lo_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;
   logic                busy;

   always_comb begin
      busy  = (cnt_ff != '0);
      trial = {rem_ff, lo_ff[QUO_BITS-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      done_in = busy && (cnt_ff == CNT_BITS'(1));
      if (start) begin
         cnt_in = CNT_BITS'(QUO_BITS);
         rem_in = num[NUM_BITS-1 -: DEN_BITS];
         lo_in  = num[QUO_BITS-1:0];
         den_in = den;
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         lo_in  = {lo_ff[QUO_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("divider started while busy");

endmodule

### rtl/sdfw_front.sv
// request intake: classifies each request and works out its dac code
module sdfw_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [sdfw_pkg::CODE_BITS-1:0] req_raw_code,
   input  logic signed [sdfw_pkg::MV_BITS-1:0] req_target_millivolts,
   input  logic [sdfw_pkg::REF_BITS-1:0]  reference_mv,
   input  logic                           queue_full,
   output sdfw_pkg::code_push_type        push,
   output logic                           div_start,
   output logic [sdfw_pkg::NUM_BITS-1:0]  div_num,
   output logic [sdfw_pkg::DEN_BITS-1:0]  div_den,
   input  logic                           div_done,
   input  logic [sdfw_pkg::QUO_BITS-1:0]  div_quotient
);
   import sdfw_pkg::*;

   localparam int CMP_BITS = MV_BITS + 1;
   localparam int WIDE_BITS = NUM_BITS + 2;

   front_state_type state_ff, state_in;

   logic signed [CMP_BITS-1:0] m_ext;
   logic signed [CMP_BITS-1:0] full_scale;
   logic signed [CMP_BITS-1:0] neg_full_scale;
   logic                       m_pos;
   logic                       m_high;
   logic                       m_low;
   logic                       ref_zero;
   logic [NUM_BITS-1:0]        uni_num;
   logic [WIDE_BITS-1:0]       bip_num;
   logic                       need_div;
   logic [CODE_BITS-1:0]       imm_code;
   logic                       accept;
   logic [CODE_BITS-1:0]       div_code;

   // range checks and numerators
   always_comb begin
      m_ext          = {req_target_millivolts[MV_BITS-1], req_target_millivolts};
      full_scale     = {2'b00, reference_mv, 4'b0000};
      neg_full_scale = -full_scale;
      m_pos          = (m_ext > 0);
      m_high         = (m_ext >= full_scale);
      m_low          = (m_ext <= neg_full_scale);
      ref_zero       = (reference_mv == '0);
      uni_num = {1'b0, req_target_millivolts[MV_BITS-2:0], 13'b0}
              + {{(NUM_BITS-REF_BITS){1'b0}}, reference_mv};
      bip_num = {{3{req_target_millivolts[MV_BITS-1]}}, req_target_millivolts, 12'b0}
              + {4'b0, reference_mv, 16'b0}
              + {{(WIDE_BITS-REF_BITS){1'b0}}, reference_mv};
   end

   // request decode
   always_comb begin
      need_div = 1'b0;
      imm_code = req_raw_code;
      div_num  = uni_num;
      case (req_type)
         REQ_UNIPOLAR: begin
            if (ref_zero || !m_pos) begin
               imm_code = CODE_ZERO;
            end else if (m_high) begin
               imm_code = CODE_MAX;
            end else begin
               need_div = 1'b1;
            end
         end
         REQ_BIPOLAR: begin
            div_num = bip_num[NUM_BITS-1:0];
            if (ref_zero) begin
               imm_code = CODE_MID;
            end else if (m_low) begin
               imm_code = CODE_ZERO;
            end else if (m_high) begin
               imm_code = CODE_MAX;
            end else begin
               need_div = 1'b1;
            end
         end
         default: begin
            imm_code = req_raw_code;
         end
      endcase
   end

   assign div_den  = {reference_mv, 1'b0};
   assign div_code = (div_quotient[QUO_BITS-1] || (&div_quotient[CODE_BITS-1:0]))
                   ? CODE_MAX : div_quotient[CODE_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid && !queue_full && need_div) begin
               state_in = FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            if (div_done) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (!queue_full) begin
               state_in = FRONT_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      accept     = 1'b0;
      div_start  = 1'b0;
      push.valid = 1'b0;
      push.code  = imm_code;
      unique case (state_ff)
         FRONT_IDLE: begin
            req_ready  = !queue_full;
            accept     = req_valid && !queue_full;
            div_start  = accept && need_div;
            push.valid = accept && !need_div;
         end
         FRONT_DIVIDE: begin
            push.code = div_code;
         end
         FRONT_PUSH: begin
            push.valid = !queue_full;
            push.code  = div_code;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/sdfw_queue.sv
// short code queue between request intake and the frame sequencer
module sdfw_queue #(
   parameter int DEPTH = sdfw_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sdfw_pkg::code_push_type        push,
   output logic                           full,
   input  logic                           pop,
   output logic                           head_valid,
   output logic [sdfw_pkg::CODE_BITS-1:0] head_code
);
   import sdfw_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [CODE_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_pop;

   always_comb begin
      full       = (count_ff == CNT_BITS'(DEPTH));
      head_valid = (count_ff != '0);
      head_code  = slot_ff[rd_ptr_ff];
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.code;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("code pushed into full queue");

endmodule

### rtl/sdfw_back.sv
// frame sequencer: turns one code into select, 48 bit phases, deselect, data low and, in pulse mode, latch events
module sdfw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sdfw_pkg::back_cfg_type         cfg,
   input  logic                           head_valid,
   input  logic [sdfw_pkg::CODE_BITS-1:0] head_code,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_chip_select_n,
   output logic                           rsp_serial_clock,
   output logic                           rsp_serial_data,
   output logic                           rsp_latch_n,
   output logic [sdfw_pkg::HOLD_BITS-1:0] rsp_hold_cycles,
   output logic [sdfw_pkg::CODE_BITS-1:0] rsp_sent_code,
   output logic                           rsp_last_event
);
   import sdfw_pkg::*;

   localparam int BIT_BITS = $clog2(CODE_BITS);
   localparam logic [BIT_BITS-1:0] BIT_LAST = BIT_BITS'(CODE_BITS - 1);
   localparam logic [1:0] PHASE_DATA     = 2'd0;
   localparam logic [1:0] PHASE_CLK_HIGH = 2'd1;
   localparam logic [1:0] PHASE_CLK_LOW  = 2'd2;

   back_state_type       state_ff, state_in;
   logic [BIT_BITS-1:0]  bit_ff, bit_in;
   logic [1:0]           phase_ff, phase_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic [CODE_BITS-1:0] shift_ff, shift_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 cs_ff, sck_ff, sdi_ff, lat_ff, last_ff;
   logic [HOLD_BITS-1:0] hold_ff;

   logic                 out_free;
   logic                 load;
   logic                 ev_cs, ev_sck, ev_sdi, ev_lat, ev_last;
   logic [HOLD_BITS-1:0] ev_hold;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (head_valid && out_free) begin
               state_in = BACK_SELECT;
            end
         end
         BACK_SELECT: begin
            if (out_free) begin
               state_in = BACK_BITS;
            end
         end
         BACK_BITS: begin
            if (out_free && bit_ff == BIT_LAST && phase_ff == PHASE_CLK_LOW) begin
               state_in = BACK_DESELECT;
            end
         end
         BACK_DESELECT: begin
            if (out_free) begin
               state_in = BACK_DATA_LOW;
            end
         end
         BACK_DATA_LOW: begin
            if (out_free) begin
               state_in = cfg.pulse_mode ? BACK_LATCH_LOW : BACK_IDLE;
            end
         end
         BACK_LATCH_LOW: begin
            if (out_free) begin
               state_in = BACK_LATCH_HIGH;
            end
         end
         BACK_LATCH_HIGH: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
      endcase
   end

   // event pin levels
   always_comb begin
      pop     = 1'b0;
      load    = 1'b0;
      ev_cs   = 1'b1;
      ev_sck  = 1'b0;
      ev_sdi  = 1'b0;
      ev_lat  = 1'b1;
      ev_hold = '0;
      ev_last = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            pop = head_valid && out_free;
         end
         BACK_SELECT: begin
            load  = out_free;
            ev_cs = 1'b0;
         end
         BACK_BITS: begin
            load    = out_free;
            ev_cs   = 1'b0;
            ev_sdi  = shift_ff[CODE_BITS-1];
            ev_sck  = (phase_ff == PHASE_CLK_HIGH);
            ev_hold = cfg.phase_hold;
         end
         BACK_DESELECT: begin
            load   = out_free;
            ev_sdi = code_ff[0];
         end
         BACK_DATA_LOW: begin
            load    = out_free;
            ev_last = !cfg.pulse_mode;
         end
         BACK_LATCH_LOW: begin
            load    = out_free;
            ev_lat  = 1'b0;
            ev_hold = cfg.latch_hold;
         end
         BACK_LATCH_HIGH: begin
            load    = out_free;
            ev_last = 1'b1;
         end
      endcase
   end

   // bit and phase counters
   always_comb begin
      bit_in   = bit_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      shift_in = shift_ff;
      if (pop) begin
         bit_in   = '0;
         phase_in = PHASE_DATA;
         code_in  = head_code;
         shift_in = head_code;
      end else if (load && state_ff == BACK_BITS) begin
         case (phase_ff)
            PHASE_DATA:     phase_in = PHASE_CLK_HIGH;
            PHASE_CLK_HIGH: phase_in = PHASE_CLK_LOW;
            default: begin
               phase_in = PHASE_DATA;
               bit_in   = bit_ff + BIT_BITS'(1);
               shift_in = {shift_ff[CODE_BITS-2:0], 1'b0};
            end
         endcase
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         bit_ff       <= '0;
         phase_ff     <= PHASE_DATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff  <= code_in;
      shift_ff <= shift_in;
      if (load) begin
         cs_ff   <= ev_cs;
         sck_ff  <= ev_sck;
         sdi_ff  <= ev_sdi;
         lat_ff  <= ev_lat;
         hold_ff <= ev_hold;
         last_ff <= ev_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chip_select_n = cs_ff;
   assign rsp_serial_clock  = sck_ff;
   assign rsp_serial_data   = sdi_ff;
   assign rsp_latch_n       = lat_ff;
   assign rsp_hold_cycles   = hold_ff;
   assign rsp_sent_code     = code_ff;
   assign rsp_last_event    = last_ff;

   a_clock_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && sck_ff |-> !cs_ff)
      else $error("serial clock high outside frame");

   a_latch_after_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !lat_ff |-> cs_ff && !sdi_ff && !sck_ff)
      else $error("latch pulse overlaps frame");

   a_last_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> cs_ff && lat_ff && !sdi_ff)
      else $error("write ended with pins not idle");

endmodule
